// ===== rtl/core/ptc_pkg.sv =====
// shared types, constants and multiply helpers for the pressure/temperature compensation unit
`timescale 1ns / 1ps

package ptc_pkg;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temp_tenths;
      logic [16:0]        press_tenths_hpa;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coef_type;

   typedef struct packed {
      logic [29:0]        rem;
      logic [63:0]        work;
      logic [30:0]        mag_den;
      logic               neg;
      logic               zero;
      logic signed [15:0] temp;
   } div_type;

   typedef enum logic [1:0] {
      CSR_CALIB_TEMP    = 2'd0,
      CSR_CALIB_PRESS_A = 2'd1,
      CSR_CALIB_PRESS_B = 2'd2,
      CSR_CALIB_PRESS_C = 2'd3
   } csr_index_type;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CALIB_W    = 48;

   localparam int FRONT_STAGES = 10;
   localparam int DIV_STAGES   = 64;
   localparam int BACK_STAGES  = 10;
   localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

   localparam logic signed [32:0] TFINE_OFFSET = 33'sd128000;
   localparam logic [31:0] RECIP_10      = 32'hCCCC_CCCD;
   localparam logic [63:0] HALF_SCALE    = 64'h0000_8000_0000_0000;
   localparam logic [20:0] P_BASE        = 21'd1048576;
   localparam logic [15:0] NUM_SCALE     = 16'd3125;
   localparam logic [52:0] Q_LIMIT       = 53'd3276800;
   localparam logic [22:0] RECIP_25      = 23'd5368710;
   localparam logic [16:0] PRESS_MAX     = 17'd131071;
   localparam logic [28:0] TEMP_POS_LIM  = 29'd32767;
   localparam logic [28:0] TEMP_NEG_LIM  = 29'd32768;

   // low 64 bits of x times an unsigned 16-bit factor
   function automatic logic [63:0] mul_u16(input logic [63:0] x, input logic [15:0] k);
      logic [79:0] pr;
      pr = x * k;
      return pr[63:0];
   endfunction

   // low 64 bits of x times a signed 16-bit factor
   function automatic logic [63:0] mul_s16(input logic [63:0] x, input logic [15:0] k);
      logic [63:0] corr;
      corr = k[15] ? {x[47:0], 16'b0} : 64'b0;
      return mul_u16(x, k) - corr;
   endfunction

endpackage

// ===== rtl/core/ptc_front.sv =====
// temperature step and pressure divisor/dividend formation, ten register stages
`timescale 1ns / 1ps

module ptc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ptc_pkg::req_type  in_data,
   input  ptc_pkg::coef_type coef,
   output logic              out_valid,
   output ptc_pkg::div_type  out_data
);

   logic [9:0]  vld_ff;
   logic [19:0] adcp_ff [1:7];

   logic [31:0] d1, d2, t2x, t3x;
   logic [31:0] m1_in, m2_in, m1_ff, m2_ff;
   logic [31:0] v1_in, m3_in, v1_ff, m3_ff;
   logic [31:0] tfine_in, tfine_ff;
   logic [31:0] thund_in, thund_ff;
   logic signed [32:0] asub_in, asub_ff;
   logic        tneg_in, tneg5_ff, tneg6_ff;
   logic [31:0] tmag_in, tmag_ff;
   logic signed [65:0] aa_full;
   logic [63:0] aa_in, aa_ff;
   logic signed [48:0] ap5_in, ap2_in, ap5_ff, ap2_ff, ap5_6_ff, ap2_6_ff;
   logic [63:0] tq_full;
   logic [28:0] tquo_in, tquo_ff;
   logic [63:0] b1_in, c3_in, b1_ff, c3_ff;
   logic [15:0] tmp_in, tmp7_ff, tmp8_ff, tmp9_ff;
   logic [63:0] b_in, x_in, b_ff, x_ff;
   logic [20:0] pdiff;
   logic [63:0] y_in, nb_in, y_ff, nb_ff;
   logic [30:0] den_in, den_ff;
   logic [63:0] num_in, num_ff;
   ptc_pkg::div_type out_in, out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[8:0], in_valid};
      end
   end

   // stage 1
   always_comb begin
      d1    = {15'b0, in_data.raw_temperature[19:3]} - {15'b0, coef.t1, 1'b0};
      d2    = {16'b0, in_data.raw_temperature[19:4]} - {16'b0, coef.t1};
      t2x   = {{16{coef.t2[15]}}, coef.t2};
      m1_in = d1 * t2x;
      m2_in = d2 * d2;
   end

   // stage 2
   always_comb begin
      t3x   = {{16{coef.t3[15]}}, coef.t3};
      v1_in = 32'($signed(m1_ff) >>> 11);
      m3_in = 32'($signed(m2_ff) >>> 12) * t3x;
   end

   // stage 3, 4
   always_comb begin
      tfine_in = v1_ff + 32'($signed(m3_ff) >>> 14);
      thund_in = 32'($signed(tfine_ff * 32'd5 + 32'd128) >>> 8);
      asub_in  = $signed({tfine_ff[31], tfine_ff}) - ptc_pkg::TFINE_OFFSET;
   end

   // stage 5
   always_comb begin
      tneg_in = thund_ff[31];
      tmag_in = thund_ff[31] ? (32'd0 - thund_ff) : thund_ff;
      aa_full = asub_ff * asub_ff;
      aa_in   = aa_full[63:0];
      ap5_in  = asub_ff * coef.p5;
      ap2_in  = asub_ff * coef.p2;
   end

   // stage 6
   always_comb begin
      tq_full = tmag_ff * ptc_pkg::RECIP_10;
      tquo_in = tq_full[63:35];
      b1_in   = ptc_pkg::mul_s16(aa_ff, coef.p6);
      c3_in   = ptc_pkg::mul_s16(aa_ff, coef.p3);
   end

   // stage 7
   always_comb begin
      if (!tneg6_ff) begin
         tmp_in = (tquo_ff > ptc_pkg::TEMP_POS_LIM) ? 16'h7FFF : tquo_ff[15:0];
      end else begin
         tmp_in = (tquo_ff > ptc_pkg::TEMP_NEG_LIM) ? 16'h8000 : (16'd0 - tquo_ff[15:0]);
      end
      b_in = b1_ff + {ap5_6_ff[46:0], 17'b0} + {{13{coef.p4[15]}}, coef.p4, 35'b0};
      x_in = 64'($signed(c3_ff) >>> 8) + {{3{ap2_6_ff[48]}}, ap2_6_ff, 12'b0}
             + ptc_pkg::HALF_SCALE;
   end

   // stage 8, 9
   always_comb begin
      pdiff  = ptc_pkg::P_BASE - {1'b0, adcp_ff[7]};
      y_in   = ptc_pkg::mul_u16(x_ff, coef.p1);
      nb_in  = {12'b0, pdiff, 31'b0} - b_ff;
      den_in = y_ff[63:33];
      num_in = ptc_pkg::mul_u16(nb_ff, ptc_pkg::NUM_SCALE);
   end

   // stage 10: magnitudes and signs for the divider
   always_comb begin
      out_in.rem     = '0;
      out_in.work    = num_ff[63] ? (64'd0 - num_ff) : num_ff;
      out_in.mag_den = den_ff[30] ? (31'd0 - den_ff) : den_ff;
      out_in.neg     = num_ff[63] ^ den_ff[30];
      out_in.zero    = (den_ff == 31'd0);
      out_in.temp    = tmp9_ff;
   end

   always_ff @(posedge clock) begin
      adcp_ff[1] <= in_data.raw_pressure;
      for (int i = 2; i <= 7; i++) begin
         adcp_ff[i] <= adcp_ff[i-1];
      end
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      v1_ff    <= v1_in;
      m3_ff    <= m3_in;
      tfine_ff <= tfine_in;
      thund_ff <= thund_in;
      asub_ff  <= asub_in;
      tneg5_ff <= tneg_in;
      tmag_ff  <= tmag_in;
      aa_ff    <= aa_in;
      ap5_ff   <= ap5_in;
      ap2_ff   <= ap2_in;
      tneg6_ff <= tneg5_ff;
      tquo_ff  <= tquo_in;
      b1_ff    <= b1_in;
      c3_ff    <= c3_in;
      ap5_6_ff <= ap5_ff;
      ap2_6_ff <= ap2_ff;
      tmp7_ff  <= tmp_in;
      b_ff     <= b_in;
      x_ff     <= x_in;
      tmp8_ff  <= tmp7_ff;
      y_ff     <= y_in;
      nb_ff    <= nb_in;
      tmp9_ff  <= tmp8_ff;
      den_ff   <= den_in;
      num_ff   <= num_in;
      out_ff   <= out_in;
   end

   assign out_valid = vld_ff[9];
   assign out_data  = out_ff;

endmodule

// ===== rtl/core/ptc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module ptc_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ptc_pkg::div_type in_data,
   output logic             out_valid,
   output ptc_pkg::div_type out_data
);

   localparam int N = ptc_pkg::DIV_STAGES;

   logic [N-1:0]     vld_ff;
   ptc_pkg::div_type stg_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      ptc_pkg::div_type cur;
      ptc_pkg::div_type step_in;
      logic [30:0]      trial;
      logic             ge;

      if (i == 0) begin : g_first
         assign cur = in_data;
      end else begin : g_next
         assign cur = stg_ff[i-1];
      end

      assign trial = {cur.rem, cur.work[63]};
      assign ge    = (trial >= cur.mag_den);

      always_comb begin
         step_in      = cur;
         step_in.rem  = ge ? 30'(trial - cur.mag_den) : trial[29:0];
         step_in.work = {cur.work[62:0], ge};
      end

      always_ff @(posedge clock) begin
         stg_ff[i] <= step_in;
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_data  = stg_ff[N-1];

endmodule

// ===== rtl/core/ptc_back.sv =====
// pressure correction terms, scaling to 0.1 hPa and saturation, ten register stages
`timescale 1ns / 1ps

module ptc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ptc_pkg::div_type  in_data,
   input  ptc_pkg::coef_type coef,
   output logic              out_valid,
   output ptc_pkg::rsp_type  out_data
);

   logic [9:0]  vld_ff;
   logic        zero_ff [1:9];
   logic [15:0] temp_ff [1:9];

   logic [63:0] p_in, p1_ff, p2_ff, p3_ff, p4_ff;
   logic [63:0] ps;
   logic [63:0] sqlo_in, sqlo_ff;
   logic [31:0] sqx_in, sqx_ff;
   logic [63:0] c2m_in, c2m_ff;
   logic [63:0] s_in, s_ff, c2_in, c2_ff, c2_4_ff;
   logic [63:0] c1m_in, c1m_ff;
   logic [63:0] sum_in, sum_ff, pp_in, pp_ff, n_in, n_ff;
   logic        nneg_in, nneg_ff, over_in, over_ff;
   logic        nneg9_ff, over9_ff;
   logic [21:0] xq_in, xq_ff;
   logic [44:0] prod_in, prod_ff;
   ptc_pkg::rsp_type out_in, out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[8:0], in_valid};
      end
   end

   always_comb begin
      p_in    = in_data.neg ? (64'd0 - in_data.work) : in_data.work;
      ps      = 64'($signed(p1_ff) >>> 13);
      sqlo_in = ps[31:0] * ps[31:0];
      sqx_in  = ps[63:32] * ps[31:0];
      c2m_in  = ptc_pkg::mul_s16(p1_ff, coef.p8);
      s_in    = sqlo_ff + {sqx_ff[30:0], 33'b0};
      c2_in   = 64'($signed(c2m_ff) >>> 19);
      c1m_in  = ptc_pkg::mul_s16(s_ff, coef.p9);
      sum_in  = p4_ff + 64'($signed(c1m_ff) >>> 25) + c2_4_ff;
      pp_in   = 64'($signed(sum_ff) >>> 8) + {{44{coef.p7[15]}}, coef.p7, 4'b0};
      n_in    = {pp_ff[60:0], 3'b0} + {pp_ff[62:0], 1'b0};
      nneg_in = n_ff[63];
      over_in = (n_ff[62:10] >= ptc_pkg::Q_LIMIT);
      xq_in   = n_ff[31:10];
      prod_in = xq_ff * ptc_pkg::RECIP_25;
   end

   always_comb begin
      out_in.temp_tenths = temp_ff[9];
      out_in.status      = zero_ff[9];
      if (zero_ff[9] || nneg9_ff) begin
         out_in.press_tenths_hpa = '0;
      end else if (over9_ff) begin
         out_in.press_tenths_hpa = ptc_pkg::PRESS_MAX;
      end else begin
         out_in.press_tenths_hpa = prod_ff[43:27];
      end
   end

   always_ff @(posedge clock) begin
      zero_ff[1] <= in_data.zero;
      temp_ff[1] <= in_data.temp;
      for (int i = 2; i <= 9; i++) begin
         zero_ff[i] <= zero_ff[i-1];
         temp_ff[i] <= temp_ff[i-1];
      end
      p1_ff    <= p_in;
      p2_ff    <= p1_ff;
      sqlo_ff  <= sqlo_in;
      sqx_ff   <= sqx_in;
      c2m_ff   <= c2m_in;
      p3_ff    <= p2_ff;
      s_ff     <= s_in;
      c2_ff    <= c2_in;
      p4_ff    <= p3_ff;
      c1m_ff   <= c1m_in;
      c2_4_ff  <= c2_ff;
      sum_ff   <= sum_in;
      pp_ff    <= pp_in;
      n_ff     <= n_in;
      nneg_ff  <= nneg_in;
      over_ff  <= over_in;
      xq_ff    <= xq_in;
      nneg9_ff <= nneg_ff;
      over9_ff <= over_ff;
      prod_ff  <= prod_in;
      out_ff   <= out_in;
   end

   assign out_valid = vld_ff[9];
   assign out_data  = out_ff;

endmodule

// ===== rtl/core/pressure_temp_compensation_unit.sv =====
// top level: calibration registers, compensation pipeline and divider
`timescale 1ns / 1ps

// stages from start to rsp_valid: 10 front stages, 64 divider stages, 10 back
// throughput: one item per cycle, busy stays low; the 64-stage divider sets the depth
// each result is shown for one cycle on rsp_valid and the receiver cannot stall
// reset clears all valid bits and the four calibration registers to zero

module pressure_temp_compensation_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ptc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output ptc_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ptc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ptc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   logic [ptc_pkg::CALIB_W-1:0] calib_temp_ff, calib_press_a_ff;
   logic [ptc_pkg::CALIB_W-1:0] calib_press_b_ff, calib_press_c_ff;
   logic [ptc_pkg::CALIB_W-1:0] rd_sel;
   ptc_pkg::csr_index_type      csr_idx;
   logic                        csr_wr;
   ptc_pkg::coef_type           coef;
   logic                        front_valid, div_valid;
   ptc_pkg::div_type            front_data, div_data;

   assign csr_idx = ptc_pkg::csr_index_type'(paddr[4:3]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign busy    = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_temp_ff    <= '0;
         calib_press_a_ff <= '0;
         calib_press_b_ff <= '0;
         calib_press_c_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            ptc_pkg::CSR_CALIB_TEMP:    calib_temp_ff    <= pwdata[ptc_pkg::CALIB_W-1:0];
            ptc_pkg::CSR_CALIB_PRESS_A: calib_press_a_ff <= pwdata[ptc_pkg::CALIB_W-1:0];
            ptc_pkg::CSR_CALIB_PRESS_B: calib_press_b_ff <= pwdata[ptc_pkg::CALIB_W-1:0];
            ptc_pkg::CSR_CALIB_PRESS_C: calib_press_c_ff <= pwdata[ptc_pkg::CALIB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         ptc_pkg::CSR_CALIB_TEMP:    rd_sel = calib_temp_ff;
         ptc_pkg::CSR_CALIB_PRESS_A: rd_sel = calib_press_a_ff;
         ptc_pkg::CSR_CALIB_PRESS_B: rd_sel = calib_press_b_ff;
         ptc_pkg::CSR_CALIB_PRESS_C: rd_sel = calib_press_c_ff;
         default:                    rd_sel = '0;
      endcase
      prdata = {{(ptc_pkg::CSR_DATA_W - ptc_pkg::CALIB_W){1'b0}}, rd_sel};
   end

   always_comb begin
      coef.t1 = calib_temp_ff[15:0];
      coef.t2 = calib_temp_ff[31:16];
      coef.t3 = calib_temp_ff[47:32];
      coef.p1 = calib_press_a_ff[15:0];
      coef.p2 = calib_press_a_ff[31:16];
      coef.p3 = calib_press_a_ff[47:32];
      coef.p4 = calib_press_b_ff[15:0];
      coef.p5 = calib_press_b_ff[31:16];
      coef.p6 = calib_press_b_ff[47:32];
      coef.p7 = calib_press_c_ff[15:0];
      coef.p8 = calib_press_c_ff[31:16];
      coef.p9 = calib_press_c_ff[47:32];
   end

   ptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .coef      (coef),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   ptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   ptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .coef      (coef),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   a_item_delivered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ptc_pkg::LATENCY) rsp_valid)
      else $error("accepted item did not produce a result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, ptc_pkg::LATENCY))
      else $error("result without a matching item");

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.press_tenths_hpa == '0))
      else $error("pressure not cleared on zero divisor");

endmodule
